FILE: sv/dsrk4_pkg.sv
`timescale 1ns / 1ps
package dsrk4_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STEP_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  // Operand widths of the shared multiplier
  localparam int unsigned OPA_W     = 36;
  localparam int unsigned OPB_W     = 33;
  localparam int unsigned PROD_W    = OPA_W + OPB_W;
  localparam int unsigned SUM_W     = OPA_W + 2;

  // Step factor h/6 as a multiply by a reciprocal; exact for any 17-bit h.
  localparam int unsigned H6_RECIP  = 43691;
  localparam int unsigned H6_SHIFT  = 18;
  localparam int unsigned H6_W      = 15;
  localparam int unsigned RECIP_W   = 16;

  // Estimate magnitude n divided by six: ((n >> 1) * DIV6_RECIP) >> DIV6_SHIFT,
  // exact for any n below 2^34.
  localparam int unsigned DIV6_RECIP = 32'd2863311531;
  localparam int unsigned DIV6_SHIFT = 33;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd2;

  localparam int unsigned UOP_COUNT = 37;
  localparam int unsigned UOP_IDX_W = 6;

  typedef struct packed {
    logic               req_type;
    logic [STEP_W-1:0]  time_step;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } dsr_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } dsr_out_t;

  // Working registers of the datapath
  typedef enum logic [3:0] {
    R_ZERO, R_X, R_V, R_T, R_J, R_SK, R_SJ, R_XM, R_VM, R_XN, R_VN, R_K, R_A
  } reg_e;

  // Second multiplier operand
  typedef enum logic [2:0] {
    C_CK, C_CB, C_H, C_HH, C_H6
  } coef_e;

  // Kind of term added to the base register
  typedef enum logic [1:0] {
    K_MUL, K_PASS, K_PASS2
  } kind_e;

  // One micro-operation: dst = base +/- term, optionally saturated to 32 bits.
  typedef struct packed {
    reg_e  dst;
    reg_e  base;
    logic  neg;
    kind_e kind;
    reg_e  src;
    coef_e coef;
    logic  sat;
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE, S_COEF, S_MUL, S_ADD, S_ACC_DIV, S_ACC_WAIT, S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic                 capture;
    logic                 coef_start;
    logic                 coef_latch;
    logic                 mul_en;
    logic                 add_en;
    logic                 acc_start;
    logic                 axis_commit;
    logic                 out_load;
    logic [UOP_IDX_W-1:0] uop_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  function automatic uop_t mk(input reg_e dst, input reg_e base, input logic neg,
                              input kind_e kind, input reg_e src, input coef_e coef,
                              input logic sat);
    uop_t u;
    u.dst  = dst;
    u.base = base;
    u.neg  = neg;
    u.kind = kind;
    u.src  = src;
    u.coef = coef;
    u.sat  = sat;
    return u;
  endfunction

  // Per-axis program: damped RK4 step, then the undamped acceleration estimate.
  function automatic uop_t uop_at(input logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    unique case (idx)
      6'd0:  u = mk(R_T,  R_ZERO, 1'b1, K_MUL,   R_X,  C_CK, 1'b0);
      6'd1:  u = mk(R_J,  R_T,    1'b1, K_MUL,   R_V,  C_CB, 1'b1);
      6'd2:  u = mk(R_SK, R_ZERO, 1'b0, K_PASS,  R_V,  C_CK, 1'b0);
      6'd3:  u = mk(R_SJ, R_ZERO, 1'b0, K_PASS,  R_J,  C_CK, 1'b0);
      6'd4:  u = mk(R_XM, R_X,    1'b0, K_MUL,   R_V,  C_HH, 1'b1);
      6'd5:  u = mk(R_VM, R_V,    1'b0, K_MUL,   R_J,  C_HH, 1'b1);
      6'd6:  u = mk(R_SK, R_SK,   1'b0, K_PASS2, R_VM, C_CK, 1'b0);
      6'd7:  u = mk(R_T,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b0);
      6'd8:  u = mk(R_J,  R_T,    1'b1, K_MUL,   R_VM, C_CB, 1'b1);
      6'd9:  u = mk(R_SJ, R_SJ,   1'b0, K_PASS2, R_J,  C_CK, 1'b0);
      6'd10: u = mk(R_XM, R_X,    1'b0, K_MUL,   R_VM, C_HH, 1'b1);
      6'd11: u = mk(R_VM, R_V,    1'b0, K_MUL,   R_J,  C_HH, 1'b1);
      6'd12: u = mk(R_SK, R_SK,   1'b0, K_PASS2, R_VM, C_CK, 1'b0);
      6'd13: u = mk(R_T,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b0);
      6'd14: u = mk(R_J,  R_T,    1'b1, K_MUL,   R_VM, C_CB, 1'b1);
      6'd15: u = mk(R_SJ, R_SJ,   1'b0, K_PASS2, R_J,  C_CK, 1'b0);
      6'd16: u = mk(R_XM, R_X,    1'b0, K_MUL,   R_VM, C_H,  1'b1);
      6'd17: u = mk(R_VM, R_V,    1'b0, K_MUL,   R_J,  C_H,  1'b1);
      6'd18: u = mk(R_SK, R_SK,   1'b0, K_PASS,  R_VM, C_CK, 1'b0);
      6'd19: u = mk(R_T,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b0);
      6'd20: u = mk(R_J,  R_T,    1'b1, K_MUL,   R_VM, C_CB, 1'b1);
      6'd21: u = mk(R_SJ, R_SJ,   1'b0, K_PASS,  R_J,  C_CK, 1'b0);
      6'd22: u = mk(R_XN, R_X,    1'b0, K_MUL,   R_SK, C_H6, 1'b1);
      6'd23: u = mk(R_VN, R_V,    1'b0, K_MUL,   R_SJ, C_H6, 1'b1);
      6'd24: u = mk(R_J,  R_ZERO, 1'b1, K_MUL,   R_XN, C_CK, 1'b1);
      6'd25: u = mk(R_A,  R_ZERO, 1'b0, K_PASS,  R_J,  C_CK, 1'b0);
      6'd26: u = mk(R_K,  R_VN,   1'b0, K_MUL,   R_J,  C_HH, 1'b1);
      6'd27: u = mk(R_XM, R_XN,   1'b0, K_MUL,   R_V,  C_HH, 1'b1);
      6'd28: u = mk(R_J,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b1);
      6'd29: u = mk(R_A,  R_A,    1'b0, K_PASS2, R_J,  C_CK, 1'b0);
      6'd30: u = mk(R_XM, R_XN,   1'b0, K_MUL,   R_K,  C_HH, 1'b1);
      6'd31: u = mk(R_K,  R_VN,   1'b0, K_MUL,   R_J,  C_HH, 1'b1);
      6'd32: u = mk(R_J,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b1);
      6'd33: u = mk(R_A,  R_A,    1'b0, K_PASS2, R_J,  C_CK, 1'b0);
      6'd34: u = mk(R_XM, R_XN,   1'b0, K_MUL,   R_K,  C_H,  1'b1);
      6'd35: u = mk(R_J,  R_ZERO, 1'b1, K_MUL,   R_XM, C_CK, 1'b1);
      6'd36: u = mk(R_A,  R_A,    1'b0, K_PASS,  R_J,  C_CK, 1'b0);
      default: u = mk(R_ZERO, R_ZERO, 1'b0, K_PASS, R_ZERO, C_CK, 1'b0);
    endcase
    return u;
  endfunction

endpackage

FILE: sv/dsrk4_stream_if.sv
`timescale 1ns / 1ps
interface dsrk4_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dsrk4_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module dsrk4_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quot_d = {quot_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

FILE: sv/dsrk4_ctrl.sv
`timescale 1ns / 1ps
module dsrk4_ctrl #(
  parameter int unsigned AXES   = 3,
  parameter int unsigned AXIS_W = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_load_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  dsrk4_pkg::dp_status_t  status_i,
  output dsrk4_pkg::ctrl_cmd_t   cmd_o,
  output logic [AXIS_W-1:0]      axis_o
);
  import dsrk4_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [UOP_IDX_W-1:0] pc_q, pc_d;
  logic [AXIS_W-1:0]    axis_q, axis_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_xfer;
  logic                 last_uop;
  logic                 last_axis;
  logic                 slot_free;

  assign in_xfer   = in_valid_i && (state_q == S_IDLE);
  assign last_uop  = (pc_q == UOP_IDX_W'(UOP_COUNT - 1));
  assign last_axis = (axis_q == AXIS_W'(AXES - 1));
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    axis_d  = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pc_d    = '0;
          axis_d  = '0;
          state_d = in_load_i ? S_RESULT : S_COEF;
        end
      end
      S_COEF: begin
        if (!status_i.div_busy) state_d = S_MUL;
      end
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        if (last_uop) begin
          state_d = S_ACC_DIV;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_ACC_DIV: state_d = S_ACC_WAIT;
      S_ACC_WAIT: begin
        if (!status_i.div_busy) begin
          pc_d = '0;
          if (last_axis) begin
            state_d = S_RESULT;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_RESULT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o         = '0;
    cmd_o.uop_idx = pc_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture    = in_xfer;
        cmd_o.coef_start = in_xfer && !in_load_i;
      end
      S_COEF:     cmd_o.coef_latch  = !status_i.div_busy;
      S_MUL:      cmd_o.mul_en      = 1'b1;
      S_ADD:      cmd_o.add_en      = 1'b1;
      S_ACC_DIV:  cmd_o.acc_start   = 1'b1;
      S_ACC_WAIT: cmd_o.axis_commit = !status_i.div_busy;
      S_RESULT:   cmd_o.out_load    = slot_free;
      default:    cmd_o.capture     = 1'b0;
    endcase
  end

  // The output register holds a result until its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign axis_o      = axis_q;
endmodule

FILE: sv/dsrk4_datapath.sv
`timescale 1ns / 1ps
module dsrk4_datapath #(
  parameter int unsigned AXES      = 3,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned AXIS_W    = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dsrk4_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dsrk4_pkg::WORD_W-1:0]           cfg_data_i,
  input  dsrk4_pkg::dsr_in_t                     in_data_i,
  input  dsrk4_pkg::ctrl_cmd_t                   cmd_i,
  input  logic [AXIS_W-1:0]                      axis_i,
  output dsrk4_pkg::dp_status_t                  status_o,
  output dsrk4_pkg::dsr_out_t                    out_data_o
);
  import dsrk4_pkg::*;

  localparam int unsigned NUM_W = WORD_W + FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SMAX38 = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SMIN38 = -SUM_W'(64'sd2147483648);
  localparam logic signed [PROD_W-1:0] SMAXP = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SMINP = -PROD_W'(64'sd2147483648);

  // Configuration registers
  logic [WORD_W-1:0] stiffness_q, mass_q, damping_q;

  // Item and coefficient registers
  logic [STEP_W-1:0]   h_q;
  logic [H6_W-1:0]     h6_q;
  logic [WORD_W-1:0]   ck_q, cb_q;

  // Architectural state and per-axis results
  logic signed [WORD_W-1:0] pos_q [AXES];
  logic signed [WORD_W-1:0] vel_q [AXES];
  logic signed [WORD_W-1:0] acc_q [AXES];

  // Working registers
  logic signed [OPA_W-1:0] t_q, j_q, sk_q, sj_q, xm_q, vm_q, xn_q, vn_q, k_q, a_q;
  logic signed [PROD_W-1:0] prod_q;
  dsr_out_t                 out_q;

  uop_t                     uop;
  logic signed [OPA_W-1:0]  src_val, base_val, res_val;
  logic signed [OPB_W-1:0]  coef_val;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [WORD_W-1:0] mq;
  logic signed [SUM_W-1:0]  term, sum;
  logic [RECIP_W+STEP_W-1:0] h6_prod;
  logic [OPA_W-1:0]         a_mag;
  logic signed [OPA_W-1:0]  acc_half;
  logic signed [OPB_W-1:0]  recip6;
  logic [NUM_W-1:0]         div0_num, quot0, quot1;
  logic [WORD_W-1:0]        div0_den, mass_eff, acc_mag;
  logic                     busy0, busy1;
  logic signed [WORD_W-1:0] load_pos [3];
  logic signed [WORD_W-1:0] load_vel [3];

  function automatic logic signed [OPA_W-1:0] sx(input logic signed [WORD_W-1:0] v);
    return OPA_W'(v);
  endfunction

  function automatic logic [WORD_W-1:0] coef_sat(input logic [NUM_W-1:0] q);
    return (|q[NUM_W-1:WORD_W-1]) ? {1'b0, {(WORD_W-1){1'b1}}} : {1'b0, q[WORD_W-2:0]};
  endfunction

  assign uop = uop_at(cmd_i.uop_idx);
  assign load_pos[0] = in_data_i.load_pos_x;
  assign load_pos[1] = in_data_i.load_pos_y;
  assign load_pos[2] = in_data_i.load_pos_z;
  assign load_vel[0] = in_data_i.load_vel_x;
  assign load_vel[1] = in_data_i.load_vel_y;
  assign load_vel[2] = in_data_i.load_vel_z;

  // Register read for the micro-operation operands
  function automatic logic signed [OPA_W-1:0] rd(input reg_e r,
      input logic signed [OPA_W-1:0] x, input logic signed [OPA_W-1:0] v,
      input logic signed [OPA_W-1:0] t, input logic signed [OPA_W-1:0] j,
      input logic signed [OPA_W-1:0] sk, input logic signed [OPA_W-1:0] sj,
      input logic signed [OPA_W-1:0] xm, input logic signed [OPA_W-1:0] vm,
      input logic signed [OPA_W-1:0] xn, input logic signed [OPA_W-1:0] vn,
      input logic signed [OPA_W-1:0] k, input logic signed [OPA_W-1:0] a);
    logic signed [OPA_W-1:0] val;
    unique case (r)
      R_X:     val = x;
      R_V:     val = v;
      R_T:     val = t;
      R_J:     val = j;
      R_SK:    val = sk;
      R_SJ:    val = sj;
      R_XM:    val = xm;
      R_VM:    val = vm;
      R_XN:    val = xn;
      R_VN:    val = vn;
      R_K:     val = k;
      R_A:     val = a;
      default: val = '0;
    endcase
    return val;
  endfunction

  assign src_val  = rd(uop.src, sx(pos_q[axis_i]), sx(vel_q[axis_i]), t_q, j_q, sk_q, sj_q,
                       xm_q, vm_q, xn_q, vn_q, k_q, a_q);
  assign base_val = rd(uop.base, sx(pos_q[axis_i]), sx(vel_q[axis_i]), t_q, j_q, sk_q, sj_q,
                       xm_q, vm_q, xn_q, vn_q, k_q, a_q);

  // Second multiplier operand
  always_comb begin
    unique case (uop.coef)
      C_CK:    coef_val = OPB_W'(ck_q);
      C_CB:    coef_val = OPB_W'(cb_q);
      C_H:     coef_val = OPB_W'(h_q);
      C_HH:    coef_val = OPB_W'(h_q[STEP_W-1:1]);
      C_H6:    coef_val = OPB_W'(h6_q);
      default: coef_val = '0;
    endcase
  end

  // Product scaled down with floor rounding, then saturated.
  always_comb begin
    prod_sh = prod_q >>> FRAC_BITS;
    if (prod_sh > SMAXP) mq = {1'b0, {(WORD_W-1){1'b1}}};
    else if (prod_sh < SMINP) mq = {1'b1, {(WORD_W-1){1'b0}}};
    else mq = prod_sh[WORD_W-1:0];
  end

  // Add stage
  always_comb begin
    unique case (uop.kind)
      K_MUL:   term = SUM_W'(mq);
      K_PASS:  term = SUM_W'(src_val);
      K_PASS2: term = SUM_W'(src_val) <<< 1;
      default: term = '0;
    endcase
    sum = SUM_W'(base_val) + (uop.neg ? -term : term);
    if (!uop.sat) res_val = sum[OPA_W-1:0];
    else if (sum > SMAX38) res_val = OPA_W'(SMAX38);
    else if (sum < SMIN38) res_val = OPA_W'(SMIN38);
    else res_val = sum[OPA_W-1:0];
  end

  // Coefficient dividers, started at the beginning of a step.
  assign mass_eff = (mass_q == '0) ? WORD_W'(1) : mass_q;
  assign div0_num = {stiffness_q, {FRAC_BITS{1'b0}}};
  assign div0_den = mass_eff;

  dsrk4_div #(.NUM_W(NUM_W), .DEN_W(WORD_W)) u_div0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.coef_start),
    .num_i  (div0_num),
    .den_i  (div0_den),
    .busy_o (busy0),
    .quot_o (quot0)
  );

  dsrk4_div #(.NUM_W(NUM_W), .DEN_W(WORD_W)) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.coef_start),
    .num_i  ({damping_q, {FRAC_BITS{1'b0}}}),
    .den_i  (mass_eff),
    .busy_o (busy1),
    .quot_o (quot1)
  );

  assign status_o.div_busy = busy0 || busy1;

  // The estimate magnitude is divided by six with a reciprocal product on the
  // shared multiplier; the quotient is the upper part of that product.
  assign a_mag    = a_q[OPA_W-1] ? OPA_W'(-a_q) : OPA_W'(a_q);
  assign acc_half = OPA_W'(a_mag >> 1);
  assign recip6   = OPB_W'(DIV6_RECIP);
  assign acc_mag  = prod_q[DIV6_SHIFT+WORD_W-1:DIV6_SHIFT];
  assign h6_prod  = in_data_i.time_step * RECIP_W'(H6_RECIP);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q <= WORD_W'(3) << FRAC_BITS;
      mass_q      <= WORD_W'(1) << FRAC_BITS;
      damping_q   <= WORD_W'(10) << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIFFNESS: stiffness_q <= cfg_data_i;
        CFG_MASS:      mass_q      <= cfg_data_i;
        CFG_DAMPING:   damping_q   <= cfg_data_i;
        default:       mass_q      <= mass_q;
      endcase
    end
  end

  // Position, velocity and estimate per axis
  for (genvar i = 0; i < AXES; i++) begin : g_axis
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end else if (cmd_i.capture && in_data_i.req_type) begin
        pos_q[i] <= (i < 3) ? load_pos[i % 3] : '0;
        vel_q[i] <= (i < 3) ? load_vel[i % 3] : '0;
        acc_q[i] <= '0;
      end else if (cmd_i.axis_commit && (axis_i == AXIS_W'(i))) begin
        pos_q[i] <= xn_q[WORD_W-1:0];
        vel_q[i] <= vn_q[WORD_W-1:0];
        acc_q[i] <= a_q[OPA_W-1] ? -acc_mag : acc_mag;
      end
    end
  end

  // Item capture, coefficients and the micro-operation pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      h_q  <= in_data_i.time_step;
      h6_q <= h6_prod[H6_SHIFT+H6_W-1:H6_SHIFT];
    end
    if (cmd_i.coef_latch) begin
      ck_q <= coef_sat(quot0);
      cb_q <= coef_sat(quot1);
    end
    if (cmd_i.mul_en) prod_q <= src_val * coef_val;
    else if (cmd_i.acc_start) prod_q <= acc_half * recip6;
    if (cmd_i.add_en) begin
      case (uop.dst)
        R_T:     t_q  <= res_val;
        R_J:     j_q  <= res_val;
        R_SK:    sk_q <= res_val;
        R_SJ:    sj_q <= res_val;
        R_XM:    xm_q <= res_val;
        R_VM:    vm_q <= res_val;
        R_XN:    xn_q <= res_val;
        R_VN:    vn_q <= res_val;
        R_K:     k_q  <= res_val;
        R_A:     a_q  <= res_val;
        default: t_q  <= t_q;
      endcase
    end
  end

  // Output register; axes beyond the third are not reported.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pos_x   <= pos_q[0];
      out_q.vel_x   <= vel_q[0];
      out_q.accel_x <= acc_q[0];
      out_q.pos_y   <= (AXES > 1) ? pos_q[(AXES > 1) ? 1 : 0] : '0;
      out_q.vel_y   <= (AXES > 1) ? vel_q[(AXES > 1) ? 1 : 0] : '0;
      out_q.accel_y <= (AXES > 1) ? acc_q[(AXES > 1) ? 1 : 0] : '0;
      out_q.pos_z   <= (AXES > 2) ? pos_q[(AXES > 2) ? 2 : 0] : '0;
      out_q.vel_z   <= (AXES > 2) ? vel_q[(AXES > 2) ? 2 : 0] : '0;
      out_q.accel_z <= (AXES > 2) ? acc_q[(AXES > 2) ? 2 : 0] : '0;
    end
  end

  assign out_data_o = out_q;
endmodule

FILE: sv/damped_spring_rk4_step_core.sv
`timescale 1ns / 1ps
// Load item: the loaded state goes from the S_RESULT state into the output register.
// Step item: worked by the serial coefficient dividers and the one shared multiplier,
// which also divides the estimate by six.
// One item is worked at a time; the next is taken while the last result waits.
// Reset (asynchronous, active low) clears the state to zero and the registers to
// k = 3.0, m = 1.0, b = 10.0.
module damped_spring_rk4_step_core #(
  parameter int unsigned AXES      = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsrk4_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsrk4_pkg::WORD_W-1:0]        cfg_data_i,
  dsrk4_stream_if.sink                        in_if,
  dsrk4_stream_if.source                      out_if
);
  import dsrk4_pkg::*;

  localparam int unsigned AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [AXIS_W-1:0] axis;
  dsr_in_t           in_data;
  dsr_out_t          out_data;

  assign in_data     = in_if.data;
  assign out_if.data = out_data;

  dsrk4_ctrl #(.AXES(AXES), .AXIS_W(AXIS_W)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_load_i  (in_data.req_type),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .axis_o     (axis)
  );

  dsrk4_datapath #(.AXES(AXES), .FRAC_BITS(FRAC_BITS), .AXIS_W(AXIS_W)) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data),
    .cmd_i     (cmd),
    .axis_i    (axis),
    .status_o  (status),
    .out_data_o(out_data)
  );
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dsrk4_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;

  dsrk4_stream_if #(.T(dsr_in_t)) in_if ();
  dsrk4_stream_if #(.T(dsr_out_t)) out_if ();

  damped_spring_rk4_step_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the spring state.
  longint unsigned spring_k = 64'd3 << 16;
  longint unsigned spring_m = 64'd1 << 16;
  longint unsigned spring_b = 64'd10 << 16;
  longint pos_st [3] = '{0, 0, 0};
  longint vel_st [3] = '{0, 0, 0};

  dsr_in_t  item_q [$];
  dsr_out_t predicted_q [$];
  int unsigned send_idle = 19;
  int unsigned recv_idle = 64;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  bit in_fired = 1'b0;

  function automatic longint sat32(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Fixed-point product: arithmetic shift floors toward minus infinity.
  function automatic longint mulq(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  function automatic longint coef_of(input longint unsigned num, input longint unsigned den);
    longint unsigned d;
    longint unsigned c;
    d = (den == 0) ? 64'd1 : den;
    c = (num << 16) / d;
    return (c > longint'(SMAX)) ? SMAX : longint'(c);
  endfunction

  function automatic longint spring_acc(input longint ck, input longint cb,
                                        input longint x, input longint v);
    return sat32(-mulq(ck, x) - mulq(cb, v));
  endfunction

  // Advances the shadow state for one item and returns the result it should produce.
  function automatic dsr_out_t rk4_predict(input dsr_in_t it);
    dsr_out_t r;
    longint acc [3];
    longint h, hh, h6, ck, cb;
    longint x, v, k1, j1, k2, j2, k3, j3, k4, j4, xm, vm, xn, vn;
    if (it.req_type) begin
      pos_st[0] = longint'(it.load_pos_x);
      pos_st[1] = longint'(it.load_pos_y);
      pos_st[2] = longint'(it.load_pos_z);
      vel_st[0] = longint'(it.load_vel_x);
      vel_st[1] = longint'(it.load_vel_y);
      vel_st[2] = longint'(it.load_vel_z);
      acc = '{0, 0, 0};
    end else begin
      h = longint'(it.time_step);
      hh = h >> 1;
      h6 = h / 6;
      ck = coef_of(spring_k, spring_m);
      cb = coef_of(spring_b, spring_m);
      for (int i = 0; i < 3; i++) begin
        x = pos_st[i];
        v = vel_st[i];
        k1 = v;
        j1 = spring_acc(ck, cb, x, v);
        xm = sat32(x + mulq(hh, k1));
        vm = sat32(v + mulq(hh, j1));
        k2 = vm;
        j2 = spring_acc(ck, cb, xm, vm);
        xm = sat32(x + mulq(hh, k2));
        vm = sat32(v + mulq(hh, j2));
        k3 = vm;
        j3 = spring_acc(ck, cb, xm, vm);
        xm = sat32(x + mulq(h, k3));
        vm = sat32(v + mulq(h, j3));
        k4 = vm;
        j4 = spring_acc(ck, cb, xm, vm);
        xn = sat32(x + mulq(h6, k1 + 2 * k2 + 2 * k3 + k4));
        vn = sat32(v + mulq(h6, j1 + 2 * j2 + 2 * j3 + j4));
        // Undamped estimate; its first midpoint uses the old velocity.
        j1 = spring_acc(ck, 0, xn, vn);
        k2 = sat32(vn + mulq(hh, j1));
        j2 = spring_acc(ck, 0, sat32(xn + mulq(hh, k1)), 0);
        k3 = sat32(vn + mulq(hh, j2));
        j3 = spring_acc(ck, 0, sat32(xn + mulq(hh, k2)), 0);
        j4 = spring_acc(ck, 0, sat32(xn + mulq(h, k3)), 0);
        acc[i] = sat32((j1 + 2 * j2 + 2 * j3 + j4) / 6);
        pos_st[i] = xn;
        vel_st[i] = vn;
      end
    end
    r.pos_x = pos_st[0][31:0];
    r.pos_y = pos_st[1][31:0];
    r.pos_z = pos_st[2][31:0];
    r.vel_x = vel_st[0][31:0];
    r.vel_y = vel_st[1][31:0];
    r.vel_z = vel_st[2][31:0];
    r.accel_x = acc[0][31:0];
    r.accel_y = acc[1][31:0];
    r.accel_z = acc[2][31:0];
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Input transfers feed the predictor.
  always @(posedge clk_i) begin
    in_fired = rst_ni && in_if.valid && in_if.ready;
    if (in_fired) predicted_q.push_back(rk4_predict(in_if.data));
  end

  // Driver: offers pending items, idling at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fired) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid <= 1'b1;
        in_if.data <= item_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Receiver ready.
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_idle);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    dsr_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (predicted_q.size() == 0) begin
        report("result transfer with no prediction pending");
      end else begin
        want = predicted_q.pop_front();
        check_field("pos_x", out_if.data.pos_x, want.pos_x);
        check_field("pos_y", out_if.data.pos_y, want.pos_y);
        check_field("pos_z", out_if.data.pos_z, want.pos_z);
        check_field("vel_x", out_if.data.vel_x, want.vel_x);
        check_field("vel_y", out_if.data.vel_y, want.vel_y);
        check_field("vel_z", out_if.data.vel_z, want.vel_z);
        check_field("accel_x", out_if.data.accel_x, want.accel_x);
        check_field("accel_y", out_if.data.accel_y, want.accel_y);
        check_field("accel_z", out_if.data.accel_z, want.accel_z);
      end
    end
  end

  function automatic dsr_in_t load_item(input logic [31:0] p, input logic [31:0] v);
    dsr_in_t it;
    it = '0;
    it.req_type = 1'b1;
    it.time_step = STEP_W'($urandom);
    it.load_pos_x = p;
    it.load_pos_y = -p;
    it.load_pos_z = p >>> 3;
    it.load_vel_x = v;
    it.load_vel_y = ~v;
    it.load_vel_z = v >>> 2;
    return it;
  endfunction

  function automatic dsr_in_t step_item(input int unsigned h);
    dsr_in_t it;
    it.req_type = 1'b0;
    it.time_step = STEP_W'(h);
    it.load_pos_x = $urandom;
    it.load_pos_y = $urandom;
    it.load_pos_z = $urandom;
    it.load_vel_x = $urandom;
    it.load_vel_y = $urandom;
    it.load_vel_z = $urandom;
    return it;
  endfunction

  // Mostly small steps; some loads, wide loads and long steps.
  function automatic dsr_in_t random_item();
    dsr_in_t it;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      it = load_item($urandom, $urandom);
      it.load_pos_y = $urandom;
      it.load_vel_z = $urandom;
    end else if (sel < 20) begin
      it = load_item(32'(int'($urandom_range(0, 2 << 20)) - (1 << 20)),
                     32'(int'($urandom_range(0, 2 << 20)) - (1 << 20)));
    end else if (sel < 85) begin
      it = step_item($urandom_range(0, 6554));
    end else if (sel < 95) begin
      it = step_item($urandom_range(0, 65536));
    end else begin
      it = step_item($urandom_range(65537, 131071));
    end
    return it;
  endfunction

  task automatic push_random(input int unsigned n);
    for (int i = 0; i < n; i++) item_q.push_back(random_item());
  endtask

  // Wait until every item has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_if.valid || predicted_q.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_STIFFNESS: spring_k = val;
      CFG_MASS:      spring_m = val;
      CFG_DAMPING:   spring_b = val;
      default: ;
    endcase
  endtask

  task automatic set_spring(input logic [31:0] k, input logic [31:0] m, input logic [31:0] b);
    write_cfg(CFG_STIFFNESS, k);
    write_cfg(CFG_MASS, m);
    write_cfg(CFG_DAMPING, b);
  endtask

  task automatic typical_spring();
    set_spring($urandom_range(1 << 14, 20 << 16), $urandom_range(1 << 15, 4 << 16),
               $urandom_range(0, 10 << 16));
  endtask

  // Sequencer.
  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at reset register values.
    item_q.push_back(step_item(65536));
    item_q.push_back(load_item(32'h7fffffff, 32'h80000000));
    item_q.push_back(step_item(0));
    item_q.push_back(step_item(131071));
    item_q.push_back(load_item(32'h80000000, 32'h7fffffff));
    item_q.push_back(step_item(1));
    item_q.push_back(step_item(65536));
    item_q.push_back(load_item(32'h0, 32'h0));
    item_q.push_back(step_item(6553));
    item_q.push_back(load_item(32'h00010000, 32'hfffe0000));
    for (int i = 0; i < 6; i++) item_q.push_back(step_item(3277));
    item_q.push_back(step_item(98304));
    item_q.push_back(load_item(32'hffffffff, 32'h00000001));
    item_q.push_back(step_item(65535));
    item_q.push_back(step_item(2));
    push_random(450);
    wait_drained();

    // Zero stiffness, damping and mass; a zero mass acts as one LSB.
    set_spring(32'h0, 32'h0, 32'h0);
    push_random(40);
    wait_drained();

    // All registers at their maximum.
    set_spring(32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_random(40);
    wait_drained();

    // Coefficients saturate with the smallest nonzero mass.
    set_spring(32'hffffffff, 32'h1, 32'hffffffff);
    push_random(30);
    wait_drained();

    // Swapped idling, with a long receiver hold-off.
    send_idle = 64;
    recv_idle = 19;
    typical_spring();
    hold_go = 1'b1;
    send_idle = 0;
    push_random(20);
    wait_drained();
    send_idle = 64;
    push_random(430);
    wait_drained();

    // No idling on either side.
    send_idle = 0;
    recv_idle = 0;
    typical_spring();
    push_random(450);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
